@@ sv/hts_pkg.sv @@
// ----------------------------------------------------------------------------
// Height sampler package
// Grid geometry, banked post memory layout and shared codes.
// ----------------------------------------------------------------------------
package hts_pkg;

   // Grid geometry: GRID_SIZE cells per axis, GRID_SPAN posts per axis
   localparam int GRID_SIZE  = 128;
   localparam int GRID_SPAN  = GRID_SIZE + 1;
   localparam int CELL_BITS  = $clog2(GRID_SIZE);

   // Posts are split over four banks by x and y parity
   localparam int HALF_SPAN  = (GRID_SPAN + 1) / 2;
   localparam int HALF_BITS  = $clog2(HALF_SPAN);
   localparam int BANK_DEPTH = HALF_SPAN * HALF_SPAN;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int NUM_BANKS  = 4;

   localparam int POST_W     = 16;
   localparam int CFG_W      = 24;

   // Rounding offset for the divide by 65535*256
   localparam logic [48:0] ROUND_HALF = 49'd8388480;
   localparam logic [16:0] DIV_CONST  = 17'd65535;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CSR_TRANS_X  = 2'd0,
      CSR_TRANS_Y  = 2'd1,
      CSR_INV_CELL = 2'd2,
      CSR_MAX_H    = 2'd3
   } csr_index_type;

endpackage

@@ sv/hts_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module hts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, hold data when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/heightmap_triangle_height_sampler_core.sv @@
// ----------------------------------------------------------------------------
// Heightmap triangle height sampler
// A query passes through every pipeline stage, up to the output register of stage 9, before its result is offered.
// Throughput: one item per cycle while rsp_tready does not stall the pipe; each post bank reads one corner per cycle.
// Loads write the banked post memory in stage 3 and give no result.
// Reset clears pipeline valid bits and sets the configuration registers to their defaults; post
// memory contents are undefined until loaded, no clearing pass is run.
// ----------------------------------------------------------------------------
module heightmap_triangle_height_sampler_core
   import hts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: post_x[7:0], post_y[15:8], sample_byte[23:16],
   //        scene_x[47:24], scene_y[71:48]
   input  logic [71:0] req_tdata,
   // tuser: kind[0]
   input  logic        req_tuser,
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: world_height[23:0]
   output logic [23:0] rsp_tdata,
   // tuser: out_of_range[0]
   output logic        rsp_tuser,
   // Configuration port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int NS = 9;

   // Configuration registers
   logic [CFG_W-1:0] trans_x_ff, trans_y_ff, inv_cell_ff, max_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_x_ff  <= '0;
         trans_y_ff  <= '0;
         inv_cell_ff <= 24'd65536;
         max_h_ff    <= 24'd25600;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TRANS_X:  trans_x_ff  <= csr_wdata;
            CSR_TRANS_Y:  trans_y_ff  <= csr_wdata;
            CSR_INV_CELL: inv_cell_ff <= csr_wdata;
            CSR_MAX_H:    max_h_ff    <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // Pipeline control: a stage advances when empty or when its successor advances
   logic [NS:1] v_ff;
   logic [NS:1] v_in;
   logic [NS:1] adv;

   always_comb begin
      adv[NS] = !v_ff[NS] || rsp_tready;
      for (int i = NS - 1; i >= 1; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   assign req_tready = adv[1];

   // Stage 1: capture item, subtract translation
   kind_type           kind1_ff, kind2_ff, kind3_ff;
   logic [7:0]         px1_ff, py1_ff, sb1_ff, px2_ff, py2_ff, sb2_ff;
   logic signed [24:0] dx1_ff, dy1_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         kind1_ff <= kind_type'(req_tuser);
         px1_ff   <= req_tdata[7:0];
         py1_ff   <= req_tdata[15:8];
         sb1_ff   <= req_tdata[23:16];
         dx1_ff   <= 25'(signed'(req_tdata[47:24])) - 25'(signed'(trans_x_ff));
         dy1_ff   <= 25'(signed'(req_tdata[71:48])) - 25'(signed'(trans_y_ff));
      end
   end

   // Stage 2: scale by reciprocal cell size
   logic signed [49:0] pxq2_ff, pyq2_ff;
   logic signed [24:0] inv_s;

   assign inv_s = signed'({1'b0, inv_cell_ff});

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         kind2_ff <= kind1_ff;
         px2_ff   <= px1_ff;
         py2_ff   <= py1_ff;
         sb2_ff   <= sb1_ff;
         pxq2_ff  <= dx1_ff * inv_s;
         pyq2_ff  <= dy1_ff * inv_s;
      end
   end

   // Stage 3: split into cell and fraction, range check, load address
   logic                 oor3_ff;
   logic [CELL_BITS-1:0] cx3_ff, cy3_ff;
   logic [7:0]           fx3_ff, fy3_ff;
   logic                 wen3_ff;
   logic [1:0]           wbank3_ff;
   logic [BANK_AW-1:0]   waddr3_ff;
   logic [POST_W-1:0]    wdata3_ff;
   logic                 oorx2, oory2, load_ok2;

   assign oorx2 = pxq2_ff[49] || (pxq2_ff[48:24] >= 25'(GRID_SIZE));
   assign oory2 = pyq2_ff[49] || (pyq2_ff[48:24] >= 25'(GRID_SIZE));
   assign load_ok2 = (11'(px2_ff) <= 11'(GRID_SIZE)) && (11'(py2_ff) <= 11'(GRID_SIZE));

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         kind3_ff  <= kind2_ff;
         oor3_ff   <= oorx2 || oory2;
         cx3_ff    <= pxq2_ff[24 +: CELL_BITS];
         cy3_ff    <= pyq2_ff[24 +: CELL_BITS];
         fx3_ff    <= pxq2_ff[23:16];
         fy3_ff    <= pyq2_ff[23:16];
         wen3_ff   <= (kind2_ff == KIND_LOAD) && load_ok2;
         wbank3_ff <= {py2_ff[0], px2_ff[0]};
         waddr3_ff <= BANK_AW'(32'(py2_ff[7:1]) * HALF_SPAN + 32'(px2_ff[7:1]));
         wdata3_ff <= {sb2_ff, sb2_ff};
      end
   end

   // Bank read addresses: each corner lands in the bank of its parity
   logic [BANK_AW-1:0] raddr [NUM_BANKS];
   logic [POST_W-1:0]  rdata [NUM_BANKS];

   always_comb begin
      logic [CELL_BITS:0] bx, by;
      for (int b = 0; b < NUM_BANKS; b++) begin
         bx = (cx3_ff[0] == b[0]) ? {1'b0, cx3_ff} : {1'b0, cx3_ff} + 1'b1;
         by = (cy3_ff[0] == b[1]) ? {1'b0, cy3_ff} : {1'b0, cy3_ff} + 1'b1;
         raddr[b] = BANK_AW'(32'(by[CELL_BITS:1]) * HALF_SPAN + 32'(bx[CELL_BITS:1]));
      end
   end

   for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
      hts_ram #(
         .WIDTH(POST_W),
         .DEPTH(BANK_DEPTH)
      ) u_ram (
         .clock  (clock),
         .wr_en  (v_ff[3] && (kind3_ff == KIND_LOAD) && wen3_ff &&
                  (wbank3_ff == 2'(g)) && adv[4]),
         .wr_addr(waddr3_ff),
         .wr_data(wdata3_ff),
         .rd_en  (adv[4]),
         .rd_addr(raddr[g]),
         .rd_data(rdata[g])
      );
   end

   // Stage 4: corner posts arrive from the banks
   logic       oor4_ff, cx0_4_ff, cy0_4_ff;
   logic [7:0] fx4_ff, fy4_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         oor4_ff  <= oor3_ff;
         cx0_4_ff <= cx3_ff[0];
         cy0_4_ff <= cy3_ff[0];
         fx4_ff   <= fx3_ff;
         fy4_ff   <= fy3_ff;
      end
   end

   // Stage 5: pick triangle, weight the three corners
   logic [POST_W-1:0] tl, tr, bl, br, ca;
   logic [8:0]        fsum, wa, wtr, wbl;
   logic              lower;
   logic [24:0]       pa5_ff, ptr5_ff, pbl5_ff;
   logic              oor5_ff;

   always_comb begin
      tl    = rdata[{cy0_4_ff, cx0_4_ff}];
      tr    = rdata[{cy0_4_ff, !cx0_4_ff}];
      bl    = rdata[{!cy0_4_ff, cx0_4_ff}];
      br    = rdata[{!cy0_4_ff, !cx0_4_ff}];
      fsum  = 9'(fx4_ff) + 9'(fy4_ff);
      lower = !fsum[8];
      ca    = lower ? tl : br;
      wa    = lower ? 9'd256 - fsum : fsum - 9'd256;
      wtr   = lower ? 9'(fx4_ff) : 9'd256 - 9'(fy4_ff);
      wbl   = lower ? 9'(fy4_ff) : 9'd256 - 9'(fx4_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         oor5_ff <= oor4_ff;
         pa5_ff  <= 25'(ca) * 25'(wa);
         ptr5_ff <= 25'(tr) * 25'(wtr);
         pbl5_ff <= 25'(bl) * 25'(wbl);
      end
   end

   // Stage 6: sum the weighted posts (at most 65535*256)
   logic [23:0] acc6_ff;
   logic        oor6_ff;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         oor6_ff <= oor5_ff;
         acc6_ff <= 24'(pa5_ff + ptr5_ff + pbl5_ff);
      end
   end

   // Stage 7: scale by max height
   logic [47:0] prod7_ff;
   logic        oor7_ff;

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         oor7_ff  <= oor6_ff;
         prod7_ff <= 48'(acc6_ff) * 48'(max_h_ff);
      end
   end

   // Stage 8: round, drop 8 bits, first fold of the divide by 65535
   logic [48:0] rn;
   logic [40:0] m8;
   logic [24:0] q0_8_ff;
   logic [25:0] r8_ff;
   logic        oor8_ff;

   assign rn = 49'(prod7_ff) + ROUND_HALF;
   assign m8 = rn[48:8];

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         oor8_ff <= oor7_ff;
         q0_8_ff <= m8[40:16];
         r8_ff   <= 26'(m8[15:0]) + 26'(m8[40:16]);
      end
   end

   // Stage 9: second fold and final correction into the output register
   logic [9:0]  q1;
   logic [16:0] r1;
   logic [24:0] quot;
   logic [23:0] wh9_ff;
   logic        oor9_ff;

   assign q1   = r8_ff[25:16];
   assign r1   = 17'(r8_ff[15:0]) + 17'(q1);
   assign quot = q0_8_ff + 25'(q1) + 25'(r1 >= DIV_CONST);

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         oor9_ff <= oor8_ff;
         wh9_ff  <= oor8_ff ? '0 : quot[23:0];
      end
   end

   // Valid bits; loads leave the pipe after writing the post memory
   always_comb begin
      v_in[1] = adv[1] ? req_tvalid : v_ff[1];
      for (int i = 2; i <= NS; i++) begin
         v_in[i] = adv[i] ? v_ff[i-1] : v_ff[i];
      end
      if (adv[4]) begin
         v_in[4] = v_ff[3] && (kind3_ff == KIND_QUERY);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign rsp_tvalid = v_ff[NS];
   assign rsp_tdata  = wh9_ff;
   assign rsp_tuser  = oor9_ff;

   // Checks
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("out-of-range result with nonzero height");

   a_height_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata <= max_h_ff))
      else $error("height above max height");

   a_load_drop: assert property (@(posedge clock) disable iff (reset)
      (v_ff[3] && (kind3_ff == KIND_LOAD) && adv[4]) |=> !v_ff[4])
      else $error("load item passed the memory stage");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
